@@ hw/rtl/ftmc_pkg.sv @@
// Shared types and constants for the flow table message counter.
package ftmc_pkg;

  localparam int unsigned IDX_MAX_W = 8;

  typedef enum logic [2:0] {
    ST_COUNTED  = 3'd0,
    ST_FULL     = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_NO_ENTRY = 3'd3,
    ST_FILTERED = 3'd4
  } status_t;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_CLOSE   = 1'b1;

  localparam logic [31:0] COUNT_ONE = 32'd1;
  localparam logic [31:0] COUNT_TWO = 32'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] message_number;
    logic [3:0]  slot;
  } res_word_t;

  typedef struct packed {
    logic                 vld;
    logic                 operation;
    logic                 filtered;
    logic [31:0]          addr;
    logic [15:0]          port;
    logic                 found;
    logic [IDX_MAX_W-1:0] found_idx;
    logic [31:0]          found_count;
    logic                 free;
    logic [IDX_MAX_W-1:0] free_idx;
  } token_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_BUMP  = 2'd1,
    CMD_CLAIM = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDX_MAX_W-1:0] idx;
    logic [31:0]          addr;
    logic [15:0]          port;
  } cmd_t;

endpackage

@@ hw/rtl/ftmc_cell.sv @@
// One table entry that checks a passing lookup word and hands it to the next entry.
module ftmc_cell
  import ftmc_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  token_t tok_in,
  input  cmd_t   cmd,
  output token_t tok_out
);

  logic        valid;
  logic [31:0] addr;
  logic [15:0] port;
  logic [31:0] count;

  logic                 hit;
  logic                 cmd_sel;
  logic [IDX_MAX_W-1:0] my_idx;
  token_t               tok_next;

  assign my_idx  = IDX_MAX_W'(INDEX);
  assign hit     = valid && (addr == tok_in.addr) && (port == tok_in.port);
  assign cmd_sel = (cmd.idx == my_idx);

  always_comb begin
    tok_next = tok_in;
    if (hit && !tok_in.found) begin
      tok_next.found       = 1'b1;
      tok_next.found_idx   = my_idx;
      tok_next.found_count = count;
    end
    if (!valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.operation   <= tok_next.operation;
    tok_out.filtered    <= tok_next.filtered;
    tok_out.addr        <= tok_next.addr;
    tok_out.port        <= tok_next.port;
    tok_out.found       <= tok_next.found;
    tok_out.found_idx   <= tok_next.found_idx;
    tok_out.found_count <= tok_next.found_count;
    tok_out.free        <= tok_next.free;
    tok_out.free_idx    <= tok_next.free_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (cmd_sel) begin
      unique case (cmd.kind)
        CMD_NONE: begin
        end
        CMD_BUMP: begin
          count <= count + COUNT_ONE;
        end
        CMD_CLAIM: begin
          valid <= 1'b1;
          count <= COUNT_TWO;
        end
        CMD_FREE: begin
          valid <= 1'b0;
          count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_sel && cmd.kind == CMD_CLAIM) begin
      addr <= cmd.addr;
      port <= cmd.port;
    end
  end

endmodule

@@ hw/rtl/flow_table_message_counter.sv @@
// Top level of the flow table message counter.
//
// A request word is taken at a clock edge where start is high and busy is low.
// Busy then stays high while the word walks the row of table entries, one
// entry per cycle, so a new request is taken only once the last is through.
// The lookup word carries the first matching entry and the lowest free entry.
// At the end of the row the table is updated and the result word is registered.
// The result appears on result with done high for exactly one cycle, in the
// same cycle that busy falls.
// A new request may be started in the cycle where done is high.
// The receiver cannot stall, so done is never held back.
// The server port register is written through cfg_wr_en and cfg_wr_data.
// The user must write it only while the block is idle; the block does not enforce this.
// Synchronous reset clears the server port, every entry and its count.
// Reset also clears any request in flight.
module flow_table_message_counter
  import ftmc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_word_t   request,
  output logic        done,
  output res_word_t   result,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] server_port;
  token_t      chain [TABLE_ENTRIES+1];
  token_t      head;
  token_t      tail;
  cmd_t        cmd;
  res_word_t   result_next;
  logic        accept;

  assign accept   = start && !busy;
  assign chain[0] = head;
  assign tail     = chain[TABLE_ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      ftmc_cell #(
        .INDEX(gi)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .tok_in (chain[gi]),
        .cmd    (cmd),
        .tok_out(chain[gi+1])
      );
    end
  endgenerate

  always_comb begin
    cmd                        = '{kind: CMD_NONE, idx: '0, addr: tail.addr, port: tail.port};
    result_next                = '0;
    result_next.status         = ST_FILTERED;
    if (tail.vld && !tail.filtered) begin
      if (tail.operation == OP_CLOSE) begin
        if (tail.found) begin
          cmd.kind           = CMD_FREE;
          cmd.idx            = tail.found_idx;
          result_next.status = ST_CLOSED;
          result_next.slot   = tail.found_idx[3:0];
        end else begin
          result_next.status = ST_NO_ENTRY;
        end
      end else if (tail.found) begin
        cmd.kind                   = CMD_BUMP;
        cmd.idx                    = tail.found_idx;
        result_next.status         = ST_COUNTED;
        result_next.message_number = tail.found_count;
        result_next.slot           = tail.found_idx[3:0];
      end else if (tail.free) begin
        cmd.kind                   = CMD_CLAIM;
        cmd.idx                    = tail.free_idx;
        result_next.status         = ST_COUNTED;
        result_next.message_number = COUNT_ONE;
        result_next.slot           = tail.free_idx[3:0];
      end else begin
        result_next.status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_port <= '0;
    end else if (cfg_wr_en) begin
      server_port <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tail.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.vld) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else begin
      head.vld <= accept;
    end
    if (accept) begin
      head.operation   <= request.operation;
      head.filtered    <= (request.src_port == server_port) ||
                          (request.dst_port != server_port);
      head.addr        <= request.src_ip;
      head.port        <= request.src_port;
      head.found       <= 1'b0;
      head.found_idx   <= '0;
      head.found_count <= '0;
      head.free        <= 1'b0;
      head.free_idx    <= '0;
    end
    if (tail.vld) begin
      result <= result_next;
    end
  end

endmodule
